// File: rtl/ttd_pkg.sv
`timescale 1ns / 1ps
// Package for the tick task dispatcher: word types, kind codes, defaults.
// No dependencies.
package ttd_pkg;

    localparam int MAX_TASKS_DEF   = 8;
    localparam int COUNT_WIDTH_DEF = 16;

    localparam logic [7:0] LEVEL_RESET = 8'hFF;

    localparam logic [1:0] KIND_ADD     = 2'd0;
    localparam logic [1:0] KIND_TICK    = 2'd1;
    localparam logic [1:0] KIND_DISABLE = 2'd2;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  task_tag;
        logic [15:0] period;
        logic [15:0] initial_delay;
        logic [7:0]  priority_req;
    } t_in_word;

    typedef struct packed {
        logic       is_dispatch;
        logic       add_accepted;
        logic [7:0] dispatched_tag;
        logic       last;
    } t_out_word;

endpackage

// File: rtl/ttd_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module ttd_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 8
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/ttd_seq.sv
`timescale 1ns / 1ps
// Sequencer for the task table: sorted insert, tick sweep, tail disable.
// Depends on ttd_pkg and ttd_ram.
module ttd_seq #(
    parameter int MAX_TASKS   = ttd_pkg::MAX_TASKS_DEF,
    parameter int COUNT_WIDTH = ttd_pkg::COUNT_WIDTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  ttd_pkg::t_in_word i_in_word,
    input  logic [7:0]        i_level,
    output logic              o_busy,
    output logic              o_res_strobe,
    output ttd_pkg::t_out_word o_res_word
);

    localparam int IW   = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CNTW = $clog2(MAX_TASKS + 1);
    localparam int CW   = COUNT_WIDTH;
    localparam int EW   = 16 + 2 * CW;
    localparam int CD_LO  = 8;
    localparam int PER_LO = 8 + CW;
    localparam int TAG_LO = 8 + 2 * CW;

    typedef enum logic [6:0] {
        S_IDLE    = 7'b0000001,
        S_ADD_RD  = 7'b0000010,
        S_ADD_CHK = 7'b0000100,
        S_ADD_WR  = 7'b0001000,
        S_TICK    = 7'b0010000,
        S_DIS_RD  = 7'b0100000,
        S_DIS_WR  = 7'b1000000
    } t_state;

    t_state             r_state, n_state;
    ttd_pkg::t_in_word  r_item, n_item;
    logic [CNTW-1:0]    r_count, n_count;
    logic [CNTW-1:0]    r_idx, n_idx;
    logic               r_dv, n_dv;
    logic [IW-1:0]      r_widx, n_widx;
    logic               r_pend, n_pend;
    logic [7:0]         r_pend_tag, n_pend_tag;
    logic               r_out_stb, n_out_stb;
    ttd_pkg::t_out_word r_out, n_out;

    logic            we, re;
    logic [IW-1:0]   waddr, raddr;
    logic [EW-1:0]   wdata, rdata;

    logic [CNTW-1:0] idx_inc, idx_dec, cnt_dec;
    logic [CW-1:0]   new_per, new_cd, rd_cd, rd_per, cd_dec;
    logic [7:0]      rd_pri, rd_tag;
    logic [EW-1:0]   new_entry;
    logic            due;

    ttd_ram #(
        .WIDTH(EW),
        .DEPTH(MAX_TASKS)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_re   (re),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    assign idx_inc = r_idx + 1'b1;
    assign idx_dec = r_idx - 1'b1;
    assign cnt_dec = r_count - 1'b1;

    assign new_per   = CW'({{CW{1'b0}}, r_item.period});
    assign new_cd    = CW'({{CW{1'b0}}, r_item.initial_delay});
    assign new_entry = {r_item.task_tag, new_per, new_cd, r_item.priority_req};

    assign rd_pri = rdata[7:0];
    assign rd_cd  = rdata[CD_LO +: CW];
    assign rd_per = rdata[PER_LO +: CW];
    assign rd_tag = rdata[TAG_LO +: 8];
    assign cd_dec = rd_cd - 1'b1;
    assign due    = (cd_dec == '0) && (rd_pri < i_level);

    always_comb begin
        n_state    = r_state;
        n_item     = r_item;
        n_count    = r_count;
        n_idx      = r_idx;
        n_dv       = 1'b0;
        n_widx     = r_widx;
        n_pend     = r_pend;
        n_pend_tag = r_pend_tag;
        n_out_stb  = 1'b0;
        n_out      = r_out;
        we         = 1'b0;
        re         = 1'b0;
        waddr      = r_idx[IW-1:0];
        raddr      = r_idx[IW-1:0];
        wdata      = new_entry;

        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_item = i_in_word;
                    case (i_in_word.kind)
                        ttd_pkg::KIND_ADD: begin
                            if (r_count >= CNTW'(MAX_TASKS)) begin
                                n_out_stb = 1'b1;
                                n_out     = '{is_dispatch: 1'b0, add_accepted: 1'b0,
                                              dispatched_tag: 8'd0, last: 1'b1};
                            end else if (r_count == '0) begin
                                n_idx   = '0;
                                n_state = S_ADD_WR;
                            end else begin
                                n_idx   = cnt_dec;
                                n_state = S_ADD_RD;
                            end
                        end
                        ttd_pkg::KIND_TICK: begin
                            n_idx   = '0;
                            n_pend  = 1'b0;
                            n_state = S_TICK;
                        end
                        ttd_pkg::KIND_DISABLE: begin
                            if (r_count != '0) begin
                                n_state = S_DIS_RD;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_ADD_RD: begin
                re      = 1'b1;
                n_state = S_ADD_CHK;
            end
            S_ADD_CHK: begin
                we    = 1'b1;
                waddr = idx_inc[IW-1:0];
                if (rd_pri > r_item.priority_req) begin
                    wdata = rdata;
                    if (r_idx == '0) begin
                        n_state = S_ADD_WR;
                    end else begin
                        n_idx   = idx_dec;
                        n_state = S_ADD_RD;
                    end
                end else begin
                    n_count   = r_count + 1'b1;
                    n_out_stb = 1'b1;
                    n_out     = '{is_dispatch: 1'b0, add_accepted: 1'b1,
                                  dispatched_tag: 8'd0, last: 1'b1};
                    n_state   = S_IDLE;
                end
            end
            S_ADD_WR: begin
                we        = 1'b1;
                n_count   = r_count + 1'b1;
                n_out_stb = 1'b1;
                n_out     = '{is_dispatch: 1'b0, add_accepted: 1'b1,
                              dispatched_tag: 8'd0, last: 1'b1};
                n_state   = S_IDLE;
            end
            S_TICK: begin
                if (r_idx < r_count) begin
                    re     = 1'b1;
                    n_idx  = idx_inc;
                    n_dv   = 1'b1;
                    n_widx = r_idx[IW-1:0];
                end
                if (r_dv) begin
                    we    = 1'b1;
                    waddr = r_widx;
                    wdata = {rd_tag, rd_per, (due ? rd_per : cd_dec), rd_pri};
                    if (due) begin
                        if (r_pend) begin
                            n_out_stb = 1'b1;
                            n_out     = '{is_dispatch: 1'b1, add_accepted: 1'b0,
                                          dispatched_tag: r_pend_tag, last: 1'b0};
                        end
                        n_pend     = 1'b1;
                        n_pend_tag = rd_tag;
                    end
                end else if (r_idx >= r_count) begin
                    if (r_pend) begin
                        n_out_stb = 1'b1;
                        n_out     = '{is_dispatch: 1'b1, add_accepted: 1'b0,
                                      dispatched_tag: r_pend_tag, last: 1'b1};
                    end
                    n_pend  = 1'b0;
                    n_state = S_IDLE;
                end
            end
            S_DIS_RD: begin
                re      = 1'b1;
                raddr   = cnt_dec[IW-1:0];
                n_state = S_DIS_WR;
            end
            S_DIS_WR: begin
                we      = 1'b1;
                waddr   = cnt_dec[IW-1:0];
                wdata   = {rdata[EW-1:8], i_level};
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_dv      <= 1'b0;
            r_pend    <= 1'b0;
            r_out_stb <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_dv      <= n_dv;
            r_pend    <= n_pend;
            r_out_stb <= n_out_stb;
        end
        r_item     <= n_item;
        r_idx      <= n_idx;
        r_widx     <= n_widx;
        r_pend_tag <= n_pend_tag;
        r_out      <= n_out;
    end

    assign o_busy       = (r_state != S_IDLE);
    assign o_res_strobe = r_out_stb;
    assign o_res_word   = r_out;

endmodule

// File: rtl/tick_task_dispatcher.sv
`timescale 1ns / 1ps
// Top level of the tick task dispatcher: level register and sequencer.
// Depends on ttd_pkg and ttd_seq.
//
//  channel  | signals                          | transfer
//  ---------+----------------------------------+-------------------------------
//  command  | start, busy, i_in_word           | start && !busy
//  result   | o_res_strobe, o_res_word         | strobe, one cycle, no stall
//  config   | i_cfg_valid, o_cfg_ready, i_cfg_data | valid && ready
//
// Add: a single write into an empty table, else a read and a compare per entry examined,
// plus a head write when the word lands at the head; a full table answers next cycle, never busy.
// Tick: sweeps every entry, one read and one write-back a cycle.
// Disable: a read then a write back, skipped on an empty table. Config ready only when idle.
// Reset empties the table and sets the level to 255. Results cannot be stalled.
module tick_task_dispatcher #(
    parameter int MAX_TASKS   = ttd_pkg::MAX_TASKS_DEF,
    parameter int COUNT_WIDTH = ttd_pkg::COUNT_WIDTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  ttd_pkg::t_in_word  i_in_word,
    output logic               o_res_strobe,
    output ttd_pkg::t_out_word o_res_word,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [7:0]         i_cfg_data
);

    logic [7:0] r_level;
    logic       seq_busy;

    assign o_cfg_ready = !seq_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level <= ttd_pkg::LEVEL_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_level <= i_cfg_data;
        end
    end

    ttd_seq #(
        .MAX_TASKS  (MAX_TASKS),
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start && !seq_busy),
        .i_in_word   (i_in_word),
        .i_level     (r_level),
        .o_busy      (seq_busy),
        .o_res_strobe(o_res_strobe),
        .o_res_word  (o_res_word)
    );

    assign busy = seq_busy;

endmodule

// File: rtl/ttd_chk.sv
`timescale 1ns / 1ps
// Port-level checker for the tick task dispatcher, bound to the top level.
// Depends on ttd_pkg.
module ttd_chk (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               start,
    input logic               busy,
    input ttd_pkg::t_in_word  i_in_word,
    input logic               o_res_strobe,
    input ttd_pkg::t_out_word o_res_word
);

    a_add_reply_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_strobe && !o_res_word.is_dispatch)
            |-> (o_res_word.last && o_res_word.dispatched_tag == 8'd0))
        else $error("add reply not final or carries a tag");

    a_dispatch_no_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_strobe && o_res_word.is_dispatch) |-> !o_res_word.add_accepted)
        else $error("dispatch report flags an accepted add");

    a_more_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_strobe && !o_res_word.last) |-> busy)
        else $error("non-final report while idle");

    a_add_answers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_in_word.kind == ttd_pkg::KIND_ADD)
            |=> (busy || (o_res_strobe && !o_res_word.is_dispatch)))
        else $error("add neither worked on nor answered");

endmodule

bind tick_task_dispatcher ttd_chk u_ttd_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .i_in_word   (i_in_word),
    .o_res_strobe(o_res_strobe),
    .o_res_word  (o_res_word)
);
